[rtl/tts_pkg.sv]
package tts_pkg;

  // Width of the running byte offset; offsets leave the block in OFFSET_BITS
  localparam int unsigned POSITION_BITS  = 32;
  localparam int unsigned OFFSET_BITS    = 32;
  // Record queue between the scanner and the token sequencer
  localparam int unsigned QUEUE_DEPTH    = 4;
  localparam int unsigned QUEUE_IDX_BITS = $clog2(QUEUE_DEPTH);

  typedef logic [POSITION_BITS-1:0] pos_t;
  typedef logic [OFFSET_BITS-1:0]   off_t;
  typedef logic [QUEUE_IDX_BITS-1:0] qptr_t;
  typedef logic [QUEUE_IDX_BITS:0]   qcnt_t;

  typedef enum logic [4:0] {
    KIND_UNKNOWN = 5'd0,
    KIND_IDENT   = 5'd1,
    KIND_NUMBER  = 5'd2,
    KIND_ADDRESS = 5'd3,
    KIND_STRING  = 5'd4,
    KIND_ARROW   = 5'd5,
    KIND_EQUAL   = 5'd6,
    KIND_NEWLINE = 5'd7,
    KIND_HASH    = 5'd8,
    KIND_PERCENT = 5'd9,
    KIND_COLON   = 5'd10,
    KIND_LBRACE  = 5'd11,
    KIND_RBRACE  = 5'd12,
    KIND_AT      = 5'd13,
    KIND_COMMA   = 5'd14,
    KIND_LPAREN  = 5'd15,
    KIND_RPAREN  = 5'd16,
    KIND_LANGLE  = 5'd17,
    KIND_RANGLE  = 5'd18,
    KIND_END     = 5'd19
  } kind_e;

  typedef enum logic [1:0] {
    ISSUE_NONE        = 2'd0,
    ISSUE_END_ESCAPE  = 2'd1,
    ISSUE_OPEN_STRING = 2'd2
  } issue_e;

  typedef enum logic [6:0] {
    MODE_IDLE   = 7'b0000001,
    MODE_EQUAL  = 7'b0000010,
    MODE_IDENT  = 7'b0000100,
    MODE_NUMBER = 7'b0001000,
    MODE_STRING = 7'b0010000,
    MODE_ESCAPE = 7'b0100000,
    MODE_DONE   = 7'b1000000
  } mode_e;

  typedef struct packed {
    kind_e  kind;
    off_t   first;
    off_t   last;
    issue_e issue;
  } token_t;

  // One queue word: the tokens caused by one input byte
  typedef struct packed {
    token_t tok0;
    token_t tok1;
    logic   two;
  } record_t;

  typedef struct packed {
    logic  hit;
    kind_e kind;
  } punct_t;

  localparam logic [7:0] CH_EQUAL     = 8'h3D;
  localparam logic [7:0] CH_GREATER   = 8'h3E;
  localparam logic [7:0] CH_UNDERLINE = 8'h5F;
  localparam logic [7:0] CH_ZERO      = 8'h30;
  localparam logic [7:0] CH_X_LOWER   = 8'h78;
  localparam logic [7:0] CH_X_UPPER   = 8'h58;
  localparam logic [7:0] CH_BACKSLASH = 8'h5C;
  localparam logic [7:0] CH_QUOTE     = 8'h22;
  localparam logic [7:0] CH_PLUS      = 8'h2B;
  localparam logic [7:0] CH_MINUS     = 8'h2D;

  function automatic off_t to_off(pos_t v);
    return off_t'(v);
  endfunction

  function automatic logic is_letter(logic [7:0] b);
    return ((b >= 8'h61) && (b <= 8'h7A)) || ((b >= 8'h41) && (b <= 8'h5A));
  endfunction

  function automatic logic is_digit(logic [7:0] b);
    return (b >= 8'h30) && (b <= 8'h39);
  endfunction

  // space, tab, vertical tab, form feed, carriage return
  function automatic logic is_blank(logic [7:0] b);
    return (b == 8'h20) || (b == 8'h09) || (b == 8'h0B) || (b == 8'h0C) || (b == 8'h0D);
  endfunction

  function automatic punct_t punct_lookup(logic [7:0] b);
    punct_t r;
    r.hit  = 1'b1;
    r.kind = KIND_UNKNOWN;
    unique case (b)
      8'h0A:   r.kind = KIND_NEWLINE;
      8'h23:   r.kind = KIND_HASH;
      8'h25:   r.kind = KIND_PERCENT;
      8'h3A:   r.kind = KIND_COLON;
      8'h7B:   r.kind = KIND_LBRACE;
      8'h7D:   r.kind = KIND_RBRACE;
      8'h40:   r.kind = KIND_AT;
      8'h2C:   r.kind = KIND_COMMA;
      8'h28:   r.kind = KIND_LPAREN;
      8'h29:   r.kind = KIND_RPAREN;
      8'h3C:   r.kind = KIND_LANGLE;
      8'h3E:   r.kind = KIND_RANGLE;
      default: r.hit  = 1'b0;
    endcase
    return r;
  endfunction

endpackage

[rtl/ir_text_token_scanner.sv]
// A token closed by a taken byte is registered in the token queue and read from its head.
// Throughput: one byte per cycle while the four-word token queue has room; the result side
//   gives one token per pop, so a byte that yields two tokens needs a pop for each of them.
// Reset (asynchronous, active low) returns the scanner to idle at offset zero and empties
//   the queue; after an end-of-input word all later bytes are dropped until reset.
module ir_text_token_scanner (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push_i,
  output logic        full_o,
  input  logic [7:0]  data_byte_i,
  input  logic        end_of_input_i,
  output logic        empty_o,
  input  logic        pop_i,
  output logic [4:0]  token_kind_o,
  output logic [31:0] span_first_o,
  output logic [31:0] span_last_o,
  output logic [1:0]  issue_code_o,
  output logic        last_of_run_o
);
  import tts_pkg::*;

  logic    take;
  logic    wr_en;
  record_t wr_rec;
  record_t head;
  logic    avail;
  logic    deq;
  logic    done;

  assign take = push_i && !full_o;

  tts_front u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .take_i         (take),
    .data_byte_i    (data_byte_i),
    .end_of_input_i (end_of_input_i),
    .wr_en_o        (wr_en),
    .wr_rec_o       (wr_rec),
    .done_o         (done)
  );

  tts_queue u_queue (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .wr_en_i  (wr_en),
    .wr_rec_i (wr_rec),
    .full_o   (full_o),
    .deq_i    (deq),
    .head_o   (head),
    .avail_o  (avail)
  );

  tts_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .head_i        (head),
    .avail_i       (avail),
    .deq_o         (deq),
    .empty_o       (empty_o),
    .pop_i         (pop_i),
    .token_kind_o  (token_kind_o),
    .span_first_o  (span_first_o),
    .span_last_o   (span_last_o),
    .issue_code_o  (issue_code_o),
    .last_of_run_o (last_of_run_o)
  );

  // an accepted end word always parks the scanner
  a_end_parks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (take && end_of_input_i) |=> done)
    else $error("scanner not done after end of input");

  // end token always closes its run
  a_end_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty_o && (token_kind_o == KIND_END)) |-> last_of_run_o)
    else $error("end token not last of run");

  // issue codes only on unknown tokens
  a_issue_kind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty_o && (issue_code_o != ISSUE_NONE)) |-> (token_kind_o == KIND_UNKNOWN))
    else $error("issue code on a known token");

  // a finished scanner never writes more tokens
  a_done_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done |-> !wr_en)
    else $error("token written after end");

endmodule

[rtl/tts_front.sv]
module tts_front (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             take_i,
  input  logic [7:0]       data_byte_i,
  input  logic             end_of_input_i,
  output logic             wr_en_o,
  output tts_pkg::record_t wr_rec_o,
  output logic             done_o
);
  import tts_pkg::*;

  mode_e      mode_q, mode_d;
  pos_t       pos_q, pos_d;
  pos_t       pstart_q, pstart_d;
  logic [1:0] plen_q, plen_d;
  logic       fzero_q, fzero_d;
  logic       addr_q, addr_d;

  pos_t       prev;
  logic       handled;
  logic       cl_v, nw_v;
  token_t     cl_tok, nw_tok, blank_tok;
  punct_t     pk;
  kind_e      num_kind;

  assign prev      = pos_q - pos_t'(1);
  assign pk        = punct_lookup(data_byte_i);
  assign num_kind  = addr_q ? KIND_ADDRESS : KIND_NUMBER;
  assign blank_tok = '{kind: KIND_UNKNOWN, first: '0, last: '0, issue: ISSUE_NONE};

  // Scanner: close the pending token, then classify the byte itself
  always_comb begin
    mode_d   = mode_q;
    pos_d    = pos_q;
    pstart_d = pstart_q;
    plen_d   = plen_q;
    fzero_d  = fzero_q;
    addr_d   = addr_q;
    handled  = 1'b0;
    cl_v     = 1'b0;
    nw_v     = 1'b0;
    cl_tok   = blank_tok;
    nw_tok   = blank_tok;

    if (take_i && (mode_q != MODE_DONE)) begin
      if (end_of_input_i) begin
        // flush pending token, then end token
        unique case (mode_q)
          MODE_EQUAL: begin
            cl_v   = 1'b1;
            cl_tok = '{KIND_EQUAL, to_off(pstart_q), to_off(pstart_q), ISSUE_NONE};
          end
          MODE_IDENT: begin
            cl_v   = 1'b1;
            cl_tok = '{KIND_IDENT, to_off(pstart_q), to_off(prev), ISSUE_NONE};
          end
          MODE_NUMBER: begin
            cl_v   = 1'b1;
            cl_tok = '{num_kind, to_off(pstart_q), to_off(prev), ISSUE_NONE};
          end
          MODE_STRING: begin
            cl_v   = 1'b1;
            cl_tok = '{KIND_UNKNOWN, to_off(pstart_q), to_off(pos_q), ISSUE_OPEN_STRING};
          end
          MODE_ESCAPE: begin
            cl_v   = 1'b1;
            cl_tok = '{KIND_UNKNOWN, to_off(pstart_q), to_off(prev), ISSUE_END_ESCAPE};
          end
          default: ;
        endcase
        nw_v   = 1'b1;
        nw_tok = '{KIND_END, to_off(pos_q), to_off(pos_q), ISSUE_NONE};
        mode_d = MODE_DONE;
      end else begin
        unique case (mode_q)
          MODE_EQUAL: begin
            cl_v = 1'b1;
            if (data_byte_i == CH_GREATER) begin
              cl_tok  = '{KIND_ARROW, to_off(pstart_q), to_off(pos_q), ISSUE_NONE};
              handled = 1'b1;
            end else begin
              cl_tok = '{KIND_EQUAL, to_off(pstart_q), to_off(pstart_q), ISSUE_NONE};
            end
            mode_d = MODE_IDLE;
          end
          MODE_IDENT: begin
            if (is_letter(data_byte_i) || is_digit(data_byte_i) ||
                (data_byte_i == CH_UNDERLINE)) begin
              handled = 1'b1;
            end else begin
              cl_v   = 1'b1;
              cl_tok = '{KIND_IDENT, to_off(pstart_q), to_off(prev), ISSUE_NONE};
              mode_d = MODE_IDLE;
            end
          end
          MODE_NUMBER: begin
            if (is_letter(data_byte_i) || is_digit(data_byte_i)) begin
              if ((plen_q == 2'd1) && fzero_q &&
                  ((data_byte_i == CH_X_LOWER) || (data_byte_i == CH_X_UPPER))) begin
                addr_d = 1'b1;
              end
              if (plen_q != 2'd3) plen_d = plen_q + 2'd1;
              handled = 1'b1;
            end else begin
              cl_v   = 1'b1;
              cl_tok = '{num_kind, to_off(pstart_q), to_off(prev), ISSUE_NONE};
              mode_d = MODE_IDLE;
            end
          end
          MODE_STRING: begin
            if (data_byte_i == CH_QUOTE) begin
              cl_v   = 1'b1;
              cl_tok = '{KIND_STRING, to_off(pstart_q), to_off(pos_q), ISSUE_NONE};
              mode_d = MODE_IDLE;
            end else if (data_byte_i == CH_BACKSLASH) begin
              mode_d = MODE_ESCAPE;
            end
            handled = 1'b1;
          end
          MODE_ESCAPE: begin
            mode_d  = MODE_STRING;
            handled = 1'b1;
          end
          default: mode_d = MODE_IDLE;
        endcase

        // byte not taken by a pending token
        if (!handled) begin
          priority if (is_blank(data_byte_i)) begin
          end else if (pk.hit) begin
            nw_v   = 1'b1;
            nw_tok = '{pk.kind, to_off(pos_q), to_off(pos_q), ISSUE_NONE};
          end else if (data_byte_i == CH_EQUAL) begin
            mode_d   = MODE_EQUAL;
            pstart_d = pos_q;
          end else if (data_byte_i == CH_QUOTE) begin
            mode_d   = MODE_STRING;
            pstart_d = pos_q;
          end else if (is_letter(data_byte_i)) begin
            mode_d   = MODE_IDENT;
            pstart_d = pos_q;
          end else if ((data_byte_i == CH_PLUS) || (data_byte_i == CH_MINUS) ||
                       is_digit(data_byte_i)) begin
            mode_d   = MODE_NUMBER;
            pstart_d = pos_q;
            plen_d   = 2'd1;
            fzero_d  = (data_byte_i == CH_ZERO);
            addr_d   = 1'b0;
          end else begin
            nw_v   = 1'b1;
            nw_tok = '{KIND_UNKNOWN, to_off(pos_q), to_off(pos_q), ISSUE_NONE};
          end
        end
        pos_d = pos_q + pos_t'(1);
      end
    end
  end

  // Pack the byte's tokens into one queue word, oldest first
  always_comb begin
    wr_en_o = cl_v | nw_v;
    if (cl_v) begin
      wr_rec_o.tok0 = cl_tok;
      wr_rec_o.tok1 = nw_tok;
      wr_rec_o.two  = nw_v;
    end else begin
      wr_rec_o.tok0 = nw_tok;
      wr_rec_o.tok1 = nw_tok;
      wr_rec_o.two  = 1'b0;
    end
  end

  assign done_o = (mode_q == MODE_DONE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q   <= MODE_IDLE;
      pos_q    <= '0;
      pstart_q <= '0;
      plen_q   <= '0;
      fzero_q  <= 1'b0;
      addr_q   <= 1'b0;
    end else begin
      mode_q   <= mode_d;
      pos_q    <= pos_d;
      pstart_q <= pstart_d;
      plen_q   <= plen_d;
      fzero_q  <= fzero_d;
      addr_q   <= addr_d;
    end
  end

endmodule

[rtl/tts_queue.sv]
module tts_queue (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             wr_en_i,
  input  tts_pkg::record_t wr_rec_i,
  output logic             full_o,
  input  logic             deq_i,
  output tts_pkg::record_t head_o,
  output logic             avail_o
);
  import tts_pkg::*;

  localparam qptr_t PtrLast = qptr_t'(QUEUE_DEPTH - 1);

  record_t mem_q [QUEUE_DEPTH];
  qptr_t   wr_ptr_q, rd_ptr_q;
  qcnt_t   cnt_q;
  logic    do_wr, do_rd;

  assign full_o  = (cnt_q == qcnt_t'(QUEUE_DEPTH));
  assign avail_o = (cnt_q != '0);
  assign do_wr   = wr_en_i && !full_o;
  assign do_rd   = deq_i && avail_o;
  assign head_o  = mem_q[rd_ptr_q];

  // word storage, no reset
  always_ff @(posedge clk_i) begin
    if (do_wr) mem_q[wr_ptr_q] <= wr_rec_i;
  end

  // pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_wr) wr_ptr_q <= (wr_ptr_q == PtrLast) ? '0 : wr_ptr_q + qptr_t'(1);
      if (do_rd) rd_ptr_q <= (rd_ptr_q == PtrLast) ? '0 : rd_ptr_q + qptr_t'(1);
      if (do_wr && !do_rd) cnt_q <= cnt_q + qcnt_t'(1);
      else if (!do_wr && do_rd) cnt_q <= cnt_q - qcnt_t'(1);
    end
  end

endmodule

[rtl/tts_back.sv]
module tts_back (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  tts_pkg::record_t head_i,
  input  logic             avail_i,
  output logic             deq_o,
  output logic             empty_o,
  input  logic             pop_i,
  output logic [4:0]       token_kind_o,
  output logic [31:0]      span_first_o,
  output logic [31:0]      span_last_o,
  output logic [1:0]       issue_code_o,
  output logic             last_of_run_o
);
  import tts_pkg::*;

  logic   sel_q, sel_d;
  logic   take;
  token_t tok;

  // walk the word one token per pop
  assign take  = pop_i && avail_i;
  assign deq_o = take && (!head_i.two || sel_q);
  assign sel_d = take ? (head_i.two && !sel_q) : sel_q;
  assign tok   = sel_q ? head_i.tok1 : head_i.tok0;

  assign empty_o       = !avail_i;
  assign token_kind_o  = tok.kind;
  assign span_first_o  = tok.first;
  assign span_last_o   = tok.last;
  assign issue_code_o  = tok.issue;
  assign last_of_run_o = !head_i.two || sel_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sel_q <= 1'b0;
    end else begin
      sel_q <= sel_d;
    end
  end

endmodule
